[rtl/core/serial_camera_image_reader_core_defines.svh]
// ----------------------------------------------------------------------------
// Serial camera image reader: assertion macros
// Shared assertion wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_CAMERA_IMAGE_READER_CORE_DEFINES_SVH
`define SERIAL_CAMERA_IMAGE_READER_CORE_DEFINES_SVH

// Property must hold at every clock edge out of reset
`define SCIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen out of reset
`define SCIR_NEVER(lbl, cond, msg) \
  `SCIR_ASSERT(lbl, !(cond), msg)

`endif

[rtl/core/scir_pkg.sv]
// ----------------------------------------------------------------------------
// Serial camera image reader: package
// Item types, job types, protocol constants and the read command builder.
// ----------------------------------------------------------------------------
package scir_pkg;

  // Request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_FAIL = 2'd3;

  // Read command bytes
  localparam logic [7:0] CMD_SERIAL    = 8'h56;
  localparam logic [7:0] CMD_READ_FBUF = 8'h32;
  localparam logic [7:0] CMD_ARG_LEN   = 8'h0C;
  localparam logic [7:0] CMD_FBUF_CTRL = 8'h0A;
  localparam logic [7:0] CMD_DELAY     = 8'h0A;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [3:0] CMD_LAST      = 4'd15;

  // JPEG end of image marker
  localparam logic [7:0] MARK_FF = 8'hFF;
  localparam logic [7:0] MARK_D9 = 8'hD9;

  // Frame lengths: header and trailer, and final trailer after the first nonzero byte
  localparam logic [2:0] FRAME_LEN = 3'd5;
  localparam logic [2:0] FINAL_LEN = 3'd4;

  // Limits and reset values
  localparam logic [21:0] PCNT_MAX       = 22'h3FFFFF;
  localparam logic [23:0] LEN_MAX        = 24'hFFFFFF;
  localparam logic [15:0] PKT_BYTES_RST  = 16'd32;

  // Job queue geometry
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = 2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_TRAILER,
    PH_SKIPZ,
    PH_FINAL
  } phase_t;

  typedef enum logic [1:0] {
    JOB_CMD,
    JOB_DATA,
    JOB_DONE,
    JOB_FAIL
  } job_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [23:0] image_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        last;
    logic [23:0] byte_count;
    logic [21:0] packets_read;
  } out_item_t;

  // Work handed from front to back. For a command, count is the read
  // offset and size the packet size; for a report, count and pkts.
  typedef struct packed {
    job_kind_t   jk;
    logic [7:0]  value;
    logic [23:0] count;
    logic [21:0] pkts;
    logic [15:0] size;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jq_stat_t;

  // Byte idx of the 16-byte read command
  function automatic logic [7:0] cmd_byte(input logic [3:0]  idx,
                                          input logic [23:0] addr,
                                          input logic [15:0] size);
    logic [7:0] b;
    case (idx)
      4'd0:    b = CMD_SERIAL;
      4'd1:    b = BYTE_ZERO;
      4'd2:    b = CMD_READ_FBUF;
      4'd3:    b = CMD_ARG_LEN;
      4'd4:    b = BYTE_ZERO;
      4'd5:    b = CMD_FBUF_CTRL;
      4'd6:    b = BYTE_ZERO;
      4'd7:    b = addr[23:16];
      4'd8:    b = addr[15:8];
      4'd9:    b = addr[7:0];
      4'd10:   b = BYTE_ZERO;
      4'd11:   b = BYTE_ZERO;
      4'd12:   b = size[15:8];
      4'd13:   b = size[7:0];
      4'd14:   b = BYTE_ZERO;
      4'd15:   b = CMD_DELAY;
      default: b = BYTE_ZERO;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/scir_front.sv]
// ----------------------------------------------------------------------------
// Serial camera image reader: front end
// Accepts requests and camera bytes, tracks the packet protocol and queues
// command, data and report jobs for the back end.
// ----------------------------------------------------------------------------
module scir_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  scir_pkg::in_item_t in_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  scir_pkg::jq_stat_t q_stat,
  output logic               job_push,
  output scir_pkg::job_t     job
);
  import scir_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fbi_r, fbi_nxt;
  logic [15:0] di_r, di_nxt;
  logic [24:0] comp_r, comp_nxt;
  logic [23:0] exp_r, exp_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [21:0] pcnt_r, pcnt_nxt;
  logic        failed_r, failed_nxt;
  logic [15:0] pkt_r, pkt_nxt;

  logic        accept;
  logic        is_start;
  logic [2:0]  fbi_inc;
  logic [15:0] di_inc;
  logic        eoi;
  logic [24:0] sum;
  logic [24:0] comp_upd;
  logic        fail_now;
  logic        pkt_end;
  logic [21:0] pcnt_inc;
  logic [23:0] bc_sat;

  // Take an item whenever the job queue has room
  assign in_full  = q_stat.full;
  assign accept   = in_push && !q_stat.full;
  assign is_start = (in_item.req_type == REQ_START);

  // Shared counters and compares
  assign fbi_inc  = fbi_r + 3'd1;
  assign di_inc   = di_r + 16'd1;
  assign eoi      = (prev_r == MARK_FF) && (in_item.rx_byte == MARK_D9);
  assign sum      = comp_r + {9'd0, di_inc};
  assign comp_upd = eoi ? sum : comp_r;
  assign fail_now = failed_r || (comp_upd > {1'b0, exp_r});
  assign pkt_end  = (di_inc >= pkt_r);
  assign pcnt_inc = (pcnt_r != PCNT_MAX) ? (pcnt_r + 22'd1) : pcnt_r;
  assign bc_sat   = comp_r[24] ? LEN_MAX : comp_r[23:0];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (is_start) begin
        phase_nxt = PH_HEADER;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (fbi_inc >= FRAME_LEN) begin
              phase_nxt = (pkt_r != 16'd0) ? PH_DATA : PH_TRAILER;
            end
          end
          PH_DATA: begin
            if (eoi || fail_now) begin
              phase_nxt = PH_SKIPZ;
            end else if (pkt_end) begin
              phase_nxt = PH_TRAILER;
            end
          end
          PH_TRAILER: begin
            if (fbi_inc >= FRAME_LEN) begin
              phase_nxt = PH_HEADER;
            end
          end
          PH_SKIPZ: begin
            if (in_item.rx_byte != BYTE_ZERO) begin
              phase_nxt = PH_FINAL;
            end
          end
          PH_FINAL: begin
            if (fbi_inc >= FINAL_LEN) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Counters, download state and queued jobs
  always_comb begin
    fbi_nxt    = fbi_r;
    di_nxt     = di_r;
    comp_nxt   = comp_r;
    exp_nxt    = exp_r;
    prev_nxt   = prev_r;
    pcnt_nxt   = pcnt_r;
    failed_nxt = failed_r;
    pkt_nxt    = cfg_we ? {cfg_wdata[15:3], 3'b000} : pkt_r;
    job_push   = 1'b0;
    job.jk     = JOB_DATA;
    job.value  = in_item.rx_byte;
    job.count  = comp_r[23:0];
    job.pkts   = pcnt_r;
    job.size   = pkt_r;
    if (accept) begin
      if (is_start) begin
        // Restart the download and issue the first read command
        exp_nxt    = in_item.image_length;
        comp_nxt   = '0;
        prev_nxt   = '0;
        failed_nxt = 1'b0;
        di_nxt     = '0;
        fbi_nxt    = '0;
        pcnt_nxt   = 22'd1;
        job_push   = 1'b1;
        job.jk     = JOB_CMD;
        job.count  = '0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            fbi_nxt = fbi_inc;
            if (fbi_inc >= FRAME_LEN) begin
              fbi_nxt = '0;
              di_nxt  = '0;
            end
          end
          PH_DATA: begin
            // Forward the data byte and watch for the end marker and overrun
            job_push   = 1'b1;
            job.jk     = JOB_DATA;
            di_nxt     = di_inc;
            prev_nxt   = in_item.rx_byte;
            comp_nxt   = comp_upd;
            failed_nxt = fail_now;
            if (!(eoi || fail_now) && pkt_end) begin
              comp_nxt = sum;
              fbi_nxt  = '0;
            end
          end
          PH_TRAILER: begin
            fbi_nxt = fbi_inc;
            if (fbi_inc >= FRAME_LEN) begin
              fbi_nxt  = '0;
              pcnt_nxt = pcnt_inc;
              job_push = 1'b1;
              job.jk   = JOB_CMD;
            end
          end
          PH_SKIPZ: begin
            if (in_item.rx_byte != BYTE_ZERO) begin
              fbi_nxt = '0;
            end
          end
          PH_FINAL: begin
            fbi_nxt = fbi_inc;
            if (fbi_inc >= FINAL_LEN) begin
              fbi_nxt   = '0;
              job_push  = 1'b1;
              job.jk    = failed_r ? JOB_FAIL : JOB_DONE;
              job.count = bc_sat;
            end
          end
          default: fbi_nxt = fbi_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      fbi_r    <= '0;
      di_r     <= '0;
      comp_r   <= '0;
      exp_r    <= '0;
      prev_r   <= '0;
      pcnt_r   <= '0;
      failed_r <= 1'b0;
      pkt_r    <= PKT_BYTES_RST;
    end else begin
      phase_r  <= phase_nxt;
      fbi_r    <= fbi_nxt;
      di_r     <= di_nxt;
      comp_r   <= comp_nxt;
      exp_r    <= exp_nxt;
      prev_r   <= prev_nxt;
      pcnt_r   <= pcnt_nxt;
      failed_r <= failed_nxt;
      pkt_r    <= pkt_nxt;
    end
  end

endmodule

[rtl/core/scir_jobq.sv]
// ----------------------------------------------------------------------------
// Serial camera image reader: job queue
// Short FIFO of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`include "serial_camera_image_reader_core_defines.svh"

module scir_jobq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scir_pkg::job_t     wr_job,
  input  logic               pop,
  output scir_pkg::job_t     head,
  output scir_pkg::jq_stat_t stat
);
  import scir_pkg::*;

  job_t             mem_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JQ_AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (JQ_AW+1)'(JQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? (rd_ptr_r + 1'b1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `SCIR_NEVER(a_jq_overflow, push && stat.full, "job pushed into a full queue")
  `SCIR_NEVER(a_jq_underflow, pop && stat.empty, "job popped from an empty queue")
  `SCIR_ASSERT(a_jq_level, cnt_r <= (JQ_AW+1)'(JQ_DEPTH), "queue level beyond depth")
  `SCIR_ASSERT(a_jq_ptrs, (wr_ptr_r - rd_ptr_r) == cnt_r[JQ_AW-1:0], "pointers disagree")

endmodule

[rtl/core/scir_back.sv]
// ----------------------------------------------------------------------------
// Serial camera image reader: back end
// Expands queued jobs into result items: a command job into its 16 bytes,
// data and report jobs into one item each, through an output register.
// ----------------------------------------------------------------------------
`include "serial_camera_image_reader_core_defines.svh"

module scir_back (
  input  logic                clk,
  input  logic                rst_n,
  input  scir_pkg::job_t      head,
  input  scir_pkg::jq_stat_t  q_stat,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output scir_pkg::out_item_t out_item
);
  import scir_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r;
  out_item_t  res;
  logic       adv;
  logic       take;
  logic       cmd_done;

  assign adv      = !out_valid_r || out_pop;
  assign take     = adv && !q_stat.empty;
  assign cmd_done = (idx_r == CMD_LAST);
  assign q_pop    = take && ((head.jk != JOB_CMD) || cmd_done);

  // Build the result for the job at the queue head
  always_comb begin
    res.kind         = KIND_DATA;
    res.value        = head.value;
    res.last         = 1'b0;
    res.byte_count   = '0;
    res.packets_read = '0;
    case (head.jk)
      JOB_CMD: begin
        res.kind  = KIND_CMD;
        res.value = cmd_byte(idx_r, head.count, head.size);
        res.last  = cmd_done;
      end
      JOB_DATA: begin
        res.kind = KIND_DATA;
      end
      JOB_DONE, JOB_FAIL: begin
        res.kind         = (head.jk == JOB_FAIL) ? KIND_FAIL : KIND_DONE;
        res.value        = BYTE_ZERO;
        res.last         = 1'b1;
        res.byte_count   = head.count;
        res.packets_read = head.pkts;
      end
      default: res.kind = KIND_DATA;
    endcase
  end

  // Step through command bytes and refill the output register
  always_comb begin
    idx_nxt = idx_r;
    if (take && (head.jk == JOB_CMD)) begin
      idx_nxt = cmd_done ? 4'd0 : (idx_r + 4'd1);
    end
    out_valid_nxt = adv ? !q_stat.empty : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload until the next item is taken
  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  `SCIR_NEVER(a_bk_orphan, (idx_r != '0) && q_stat.empty, "command run lost its job")

endmodule

[rtl/core/serial_camera_image_reader_core.sv]
// A result reaches out_item through the job queue and then the output register.
// Throughput: one item per cycle while the 4-entry job queue has room.
// A read command holds the back end for 16 bytes, one per cycle unless the output stalls.
// Every other job gives a single result item.
// Reset: synchronous, active low; idle, queue empty, packet size back to 32.
// ----------------------------------------------------------------------------
// Serial camera image reader: top level
// Front end tracks the camera packet protocol, back end emits result items.
// ----------------------------------------------------------------------------
module serial_camera_image_reader_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  scir_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output scir_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import scir_pkg::*;

  jq_stat_t q_stat;
  logic     job_push;
  job_t     job;
  logic     q_pop;
  job_t     q_head;

  scir_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job      (job)
  );

  scir_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wr_job(job),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  scir_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule

[verif/serial_camera_image_reader_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial camera image reader: testbench
// Drives start requests and camera bytes through the input queue, tracks the
// packet-read protocol in a local predictor and checks every result item
// field by field. A short directed table comes first, then random downloads
// under several packet sizes, with random idling on both sides.
// ----------------------------------------------------------------------------
module serial_camera_image_reader_core_tb;
  import scir_pkg::*;

  localparam int RANDOM_ITEMS  = 400;
  localparam int PHASES        = 8;
  localparam int DRAIN_CYCLES  = 8;
  localparam int END_CYCLES    = 20;
  localparam int RUN_LIMIT_NS  = 3_000_000;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_pop   = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_full;
  logic        out_empty;
  out_item_t   out_item;

  // Download tracker state
  phase_t      pred_phase;
  logic [2:0]  frame_idx;
  logic [15:0] data_cnt;
  logic [24:0] done_bytes;
  logic [23:0] expect_len;
  logic [7:0]  prev_data;
  logic [21:0] pkt_cnt;
  logic        failed;
  logic [15:0] pkt_size;

  out_item_t   step_out[$];
  out_item_t   due_out[$];
  dir_row_t    dir_table[$];
  bit          steady     = 1'b0;
  int          fail_count = 0;

  serial_camera_image_reader_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue the 16 bytes of a read command and advance to the header
  function automatic void queue_read_cmd();
    logic [7:0] cmd [16];
    out_item_t  r;
    cmd[0]  = CMD_SERIAL;          cmd[1]  = BYTE_ZERO;
    cmd[2]  = CMD_READ_FBUF;       cmd[3]  = CMD_ARG_LEN;
    cmd[4]  = BYTE_ZERO;           cmd[5]  = CMD_FBUF_CTRL;
    cmd[6]  = BYTE_ZERO;           cmd[7]  = done_bytes[23:16];
    cmd[8]  = done_bytes[15:8];    cmd[9]  = done_bytes[7:0];
    cmd[10] = BYTE_ZERO;           cmd[11] = BYTE_ZERO;
    cmd[12] = pkt_size[15:8];      cmd[13] = pkt_size[7:0];
    cmd[14] = BYTE_ZERO;           cmd[15] = CMD_DELAY;
    for (int k = 0; k < 16; k++) begin
      r = '0;
      r.kind  = KIND_CMD;
      r.value = cmd[k];
      r.last  = (k == CMD_LAST);
      step_out = {step_out, r};
    end
    if (pkt_cnt != PCNT_MAX) pkt_cnt++;
    frame_idx  = '0;
    pred_phase = PH_HEADER;
  endfunction

  // Advance the tracker by one accepted item, collecting its results
  function automatic void track_download(in_item_t it);
    out_item_t r;
    logic      marker;
    r = '0;
    if (it.req_type == REQ_START) begin
      expect_len = it.image_length;
      done_bytes = '0;
      prev_data  = '0;
      failed     = 1'b0;
      pkt_cnt    = '0;
      data_cnt   = '0;
      queue_read_cmd();
      return;
    end
    case (pred_phase)
      PH_HEADER: begin
        frame_idx++;
        if (frame_idx >= FRAME_LEN) begin
          frame_idx = '0;
          data_cnt  = '0;
          if (pkt_size != 16'd0) pred_phase = PH_DATA;
          else pred_phase = PH_TRAILER;
        end
      end
      PH_DATA: begin
        r.kind  = KIND_DATA;
        r.value = it.rx_byte;
        step_out = {step_out, r};
        data_cnt++;
        marker = (prev_data == MARK_FF) && (it.rx_byte == MARK_D9);
        if (marker) done_bytes = done_bytes + 25'(data_cnt);
        if (done_bytes > 25'(expect_len)) failed = 1'b1;
        prev_data = it.rx_byte;
        if (marker || failed) begin
          pred_phase = PH_SKIPZ;
        end else if (data_cnt >= pkt_size) begin
          done_bytes = done_bytes + 25'(data_cnt);
          frame_idx  = '0;
          pred_phase = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        frame_idx++;
        if (frame_idx >= FRAME_LEN) queue_read_cmd();
      end
      PH_SKIPZ: begin
        if (it.rx_byte != BYTE_ZERO) begin
          frame_idx  = '0;
          pred_phase = PH_FINAL;
        end
      end
      PH_FINAL: begin
        frame_idx++;
        if (frame_idx >= FINAL_LEN) begin
          frame_idx  = '0;
          pred_phase = PH_IDLE;
          r.kind     = failed ? KIND_FAIL : KIND_DONE;
          r.last     = 1'b1;
          r.byte_count   = (done_bytes > 25'(LEN_MAX)) ? LEN_MAX : done_bytes[23:0];
          r.packets_read = pkt_cnt;
          step_out = {step_out, r};
        end
      end
      default: ;
    endcase
  endfunction

  // Pick the next item from where the download stands: mostly well formed
  function automatic in_item_t next_camera_item();
    in_item_t it;
    int       pick;
    it.req_type = REQ_BYTE;
    it.rx_byte  = 8'($urandom);
    pick = $urandom_range(9, 0);
    if (pick < 6)       it.image_length = 24'($urandom_range(48, 0));
    else if (pick < 8)  it.image_length = 24'($urandom_range(400, 0));
    else if (pick == 8) it.image_length = 24'($urandom);
    else                it.image_length = LEN_MAX;
    if (pred_phase == PH_IDLE) begin
      if ($urandom_range(99, 0) < 85) it.req_type = REQ_START;
    end else if ($urandom_range(99, 0) < 3) begin
      it.req_type = REQ_START;
    end else if (pred_phase == PH_DATA) begin
      if (prev_data == MARK_FF && $urandom_range(1, 0) == 1) it.rx_byte = MARK_D9;
      else if ($urandom_range(99, 0) < 8) it.rx_byte = MARK_FF;
    end else if (pred_phase == PH_SKIPZ && $urandom_range(99, 0) < 60) begin
      it.rx_byte = BYTE_ZERO;
    end
    return it;
  endfunction

  function automatic void add_row(logic req, logic [7:0] b, logic [23:0] len,
                                  bit typed = 1'b0, logic [1:0] kind = KIND_CMD,
                                  logic [7:0] value = 8'h00, logic last = 1'b0,
                                  logic [23:0] bc = 24'd0, logic [21:0] pr = 22'd0);
    dir_row_t row;
    row.it    = '{req_type: req, rx_byte: b, image_length: len};
    row.typed = typed;
    row.res   = '{kind: kind, value: value, last: last, byte_count: bc,
                  packets_read: pr};
    dir_table = {dir_table, row};
  endfunction

  // Offer one item, hold it until accepted, then record what it should cause
  task automatic send_item(in_item_t it, bit typed, out_item_t res);
    while (!steady && $urandom_range(99, 0) < 36) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    step_out.delete();
    track_download(it);
    if (typed) due_out = {due_out, res};
    else due_out = {due_out, step_out};
  endtask

  // Drain all results and let the pipeline go quiet
  task automatic settle();
    in_push <= 1'b0;
    while (due_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_packet_bytes(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    pkt_size = v & 16'hFFF8;
  endtask

  // Check each popped result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (due_out.size() == 0) begin
        $error("unexpected result: kind %0d value %02h last %0d", out_item.kind,
               out_item.value, out_item.last);
        fail_count++;
      end else begin
        want = due_out.pop_front();
        if (out_item.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_item.kind);
          fail_count++;
        end
        if (out_item.value !== want.value) begin
          $error("value: expected %02h, actual %02h", want.value, out_item.value);
          fail_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_item.last);
          fail_count++;
        end
        if (out_item.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", want.byte_count,
                 out_item.byte_count);
          fail_count++;
        end
        if (out_item.packets_read !== want.packets_read) begin
          $error("packets_read: expected %0d, actual %0d", want.packets_read,
                 out_item.packets_read);
          fail_count++;
        end
      end
    end
    out_pop <= steady || ($urandom_range(99, 0) >= 36);
  end

  initial begin
    in_item_t    it;
    logic [15:0] cfg_val;
    int          counted;

    pred_phase = PH_IDLE;
    frame_idx  = '0;
    data_cnt   = '0;
    done_bytes = '0;
    expect_len = '0;
    prev_data  = '0;
    pkt_cnt    = '0;
    failed     = 1'b0;
    pkt_size   = PKT_BYTES_RST;

    // Camera byte while idle: dropped
    add_row(REQ_BYTE, MARK_FF, 24'd0);
    // Start at full length, then restart while busy
    add_row(REQ_START, 8'h00, LEN_MAX);
    add_row(REQ_START, 8'h00, 24'd3);
    // Header content is counted, not checked
    add_row(REQ_BYTE, 8'h00, 24'd0);
    add_row(REQ_BYTE, MARK_FF, 24'd0);
    add_row(REQ_BYTE, 8'h5A, 24'd0);
    add_row(REQ_BYTE, 8'hA5, 24'd0);
    add_row(REQ_BYTE, MARK_D9, 24'd0);
    // First data byte D9 cannot end the image; FF D9 ends it at exactly the length
    add_row(REQ_BYTE, MARK_D9, 24'd0, 1'b1, KIND_DATA, MARK_D9);
    add_row(REQ_BYTE, MARK_FF, 24'd0, 1'b1, KIND_DATA, MARK_FF);
    add_row(REQ_BYTE, MARK_D9, 24'd0, 1'b1, KIND_DATA, MARK_D9);
    // Skip a zero, then nonzero byte plus four trailer bytes
    add_row(REQ_BYTE, 8'h00, 24'd0);
    add_row(REQ_BYTE, 8'h80, 24'd0);
    add_row(REQ_BYTE, 8'h11, 24'd0);
    add_row(REQ_BYTE, 8'h22, 24'd0);
    add_row(REQ_BYTE, 8'h33, 24'd0);
    add_row(REQ_BYTE, 8'h00, 24'd0, 1'b1, KIND_DONE, 8'h00, 1'b1, 24'd3, 22'd1);
    // Length one: marker overruns it and the download fails
    add_row(REQ_START, MARK_FF, 24'd1);
    add_row(REQ_BYTE, 8'h01, 24'd0);
    add_row(REQ_BYTE, 8'h02, 24'd0);
    add_row(REQ_BYTE, 8'h03, 24'd0);
    add_row(REQ_BYTE, 8'h04, 24'd0);
    add_row(REQ_BYTE, 8'h05, 24'd0);
    add_row(REQ_BYTE, MARK_FF, 24'd0, 1'b1, KIND_DATA, MARK_FF);
    add_row(REQ_BYTE, MARK_D9, 24'd0, 1'b1, KIND_DATA, MARK_D9);
    add_row(REQ_BYTE, 8'h01, 24'd0);
    add_row(REQ_BYTE, 8'hFE, 24'd0);
    add_row(REQ_BYTE, 8'h7F, 24'd0);
    add_row(REQ_BYTE, 8'h00, 24'd0);
    add_row(REQ_BYTE, 8'hC3, 24'd0, 1'b1, KIND_FAIL, 8'h00, 1'b1, 24'd2, 22'd1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table at the smallest nonzero packet size; low bits must be dropped
    settle();
    write_packet_bytes(16'h000F);
    foreach (dir_table[i]) send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].res);

    // Random downloads, one packet size per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       cfg_val = 16'h0007;
        1:       cfg_val = 16'hFFFF;
        2:       cfg_val = 16'h0008;
        default: begin
          if ($urandom_range(9, 0) < 3) cfg_val = 16'($urandom);
          else cfg_val = 16'($urandom_range(40, 0));
        end
      endcase
      write_packet_bytes(cfg_val);
      steady  = (ph == 3);
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) begin
        it = next_camera_item();
        if (!(pred_phase == PH_IDLE && it.req_type == REQ_BYTE)) counted++;
        send_item(it, 1'b0, '0);
      end
    end

    // Drain and let any stray result show up
    steady = 1'b0;
    in_push <= 1'b0;
    while (due_out.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
